// File: hw/rtl/pmmc_pkg.sv
// ----------------------------------------------------------------------------
// pmmc_pkg - shared types and constants of the port-mapped memory card
// Command/status structs between controller and datapath, port decode codes,
// register indexes and fixed bus constants.
// ----------------------------------------------------------------------------
package pmmc_pkg;

  localparam int PORT_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 16;
  localparam int KB_CFG_W = 6;             // width of the size register field
  localparam int KB_REG_W = 7;             // holds the size up to 64 KB
  localparam int KB_SHIFT = 10;            // 1024 bytes per kilobyte
  localparam int UPPER_W  = PORT_W - KB_SHIFT;  // pointer bits above the KB offset
  localparam int STEP_W   = $clog2(UPPER_W);

  localparam logic [BYTE_W-1:0] STATUS_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] FLOAT_BUS   = 8'hFF;
  localparam logic [BYTE_W-1:0] REG_RESET   = 8'hFF;
  localparam int                READ_BIT    = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PORT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PORT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_PORT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RDATA_PORT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WDATA_PORT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_PORT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_KB    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NOOP_CODE    = 3'd7;

  typedef enum logic [2:0] {
    SEL_LOW,
    SEL_HIGH,
    SEL_CMD,
    SEL_RDATA,
    SEL_WDATA,
    SEL_STATUS,
    SEL_NONE
  } port_sel_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_REG_WR,
    KIND_REG_RD,
    KIND_MEM_RD,
    KIND_MEM_WR
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WRAP,
    ST_MEM,
    ST_RDWAIT,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic reg_write;
    logic res_direct;
    logic wrap_start;
    logic wrap_step;
    logic mem_write;
    logic mem_read;
    logic res_mem;
    logic out_load;
    logic clr_step;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  clr_last;
    logic  wrap_last;
    logic  out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/pmmc_ctrl.sv
// ----------------------------------------------------------------------------
// pmmc_ctrl - sequencer of the port-mapped memory card
// Runs the clearing pass, takes one bus access at a time and steps the
// datapath through decode, address wrap, memory access and result delivery.
// ----------------------------------------------------------------------------
module pmmc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  pmmc_pkg::dp_status_t  status,
  output pmmc_pkg::ctrl_cmd_t   cmd
);
  import pmmc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status.kind)
          KIND_REG_WR: begin
            cmd.reg_write = 1'b1;
            state_nxt     = ST_IDLE;
          end
          KIND_REG_RD: begin
            cmd.res_direct = 1'b1;
            state_nxt      = ST_SEND;
          end
          KIND_MEM_RD, KIND_MEM_WR: begin
            cmd.wrap_start = 1'b1;
            state_nxt      = ST_WRAP;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_WRAP: begin
        cmd.wrap_step = 1'b1;
        if (status.wrap_last) begin
          state_nxt = ST_MEM;
        end
      end
      ST_MEM: begin
        if (status.kind == KIND_MEM_WR) begin
          cmd.mem_write = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.mem_read = 1'b1;
          state_nxt    = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        cmd.res_mem = 1'b1;
        state_nxt   = ST_SEND;
      end
      ST_SEND: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output register busy");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_EXEC))
    else $error("accepted word not decoded next cycle");

  a_wrap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRAP && status.wrap_last) |=> (state_r == ST_MEM))
    else $error("memory access did not follow address wrap");

endmodule

// File: hw/rtl/pmmc_dp.sv
// ----------------------------------------------------------------------------
// pmmc_dp - datapath of the port-mapped memory card
// Configuration and address registers, port decode, bit-serial size wrap,
// card memory with clearing pass, and the output register.
// ----------------------------------------------------------------------------
module pmmc_dp #(
  parameter int MEMORY_BYTES = 32768
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pmmc_pkg::ctrl_cmd_t               cmd,
  output pmmc_pkg::dp_status_t              status,
  input  logic [pmmc_pkg::PORT_W+pmmc_pkg::BYTE_W-1:0] in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_we,
  input  logic [pmmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmmc_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pmmc_pkg::BYTE_W-1:0]       out_tdata
);
  import pmmc_pkg::*;

  localparam int AW     = $clog2(MEMORY_BYTES);
  localparam int MAX_KB = MEMORY_BYTES / 1024;
  localparam int FULL_W = KB_REG_W + KB_SHIFT;

  // configuration
  logic [PORT_W-1:0]   low_port_r, high_port_r, cmd_port_r;
  logic [PORT_W-1:0]   rdata_port_r, wdata_port_r, status_port_r;
  logic [KB_REG_W-1:0] kb_r;
  logic [BYTE_W-1:0]   noop_r;
  logic [KB_CFG_W-1:0] kb_in;

  // card registers
  logic [BYTE_W-1:0]   lo_latch_r, hi_latch_r, command_r;
  logic [PORT_W-1:0]   rptr_r, wptr_r;

  // captured word
  logic                mode_r;
  logic [PORT_W-1:0]   port_r;
  logic [BYTE_W-1:0]   value_r;

  port_sel_t           sel;
  kind_t               kind;

  // wrap unit
  logic [UPPER_W-1:0]  div_r;
  logic [KB_SHIFT-1:0] off_r;
  logic [KB_REG_W-1:0] rem_r, rem_nxt;
  logic [KB_REG_W:0]   trial, kb_ext;
  logic [STEP_W-1:0]   step_r;
  logic [PORT_W-1:0]   ptr_sel;
  logic [FULL_W-1:0]   full_addr;

  // memory
  logic [BYTE_W-1:0]   mem [MEMORY_BYTES];
  logic [AW-1:0]       clr_cnt_r;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic [BYTE_W-1:0]   mem_wdata;
  logic [BYTE_W-1:0]   mem_q_r;

  // result
  logic [BYTE_W-1:0]   res_r, res_direct;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_data_r;

  assign kb_in = cfg_wdata[KB_CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_port_r    <= PORT_W'(0);
      high_port_r   <= PORT_W'(1);
      cmd_port_r    <= PORT_W'(2);
      rdata_port_r  <= PORT_W'(3);
      wdata_port_r  <= PORT_W'(4);
      status_port_r <= PORT_W'(5);
      kb_r          <= KB_REG_W'(MAX_KB);
      noop_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_PORT:     low_port_r    <= cfg_wdata;
        REG_HIGH_PORT:    high_port_r   <= cfg_wdata;
        REG_COMMAND_PORT: cmd_port_r    <= cfg_wdata;
        REG_RDATA_PORT:   rdata_port_r  <= cfg_wdata;
        REG_WDATA_PORT:   wdata_port_r  <= cfg_wdata;
        REG_STATUS_PORT:  status_port_r <= cfg_wdata;
        REG_MEMORY_KB: begin
          // drop sizes outside 1..MAX_KB
          if (kb_in != '0 && {1'b0, kb_in} <= KB_REG_W'(MAX_KB)) begin
            kb_r <= {1'b0, kb_in};
          end
        end
        REG_NOOP_CODE:    noop_r        <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_tuser;
      port_r  <= in_tdata[PORT_W-1:0];
      value_r <= in_tdata[PORT_W+BYTE_W-1:PORT_W];
    end
  end

  // fixed-priority port decode
  always_comb begin
    priority if (port_r == low_port_r)    sel = SEL_LOW;
    else if (port_r == high_port_r)       sel = SEL_HIGH;
    else if (port_r == cmd_port_r)        sel = SEL_CMD;
    else if (port_r == rdata_port_r)      sel = SEL_RDATA;
    else if (port_r == wdata_port_r)      sel = SEL_WDATA;
    else if (port_r == status_port_r)     sel = SEL_STATUS;
    else                                  sel = SEL_NONE;
  end

  always_comb begin
    kind       = KIND_NONE;
    res_direct = FLOAT_BUS;
    unique case (sel)
      SEL_LOW: begin
        kind       = mode_r ? KIND_REG_WR : KIND_REG_RD;
        res_direct = lo_latch_r;
      end
      SEL_HIGH: begin
        kind       = mode_r ? KIND_REG_WR : KIND_REG_RD;
        res_direct = hi_latch_r;
      end
      SEL_CMD: begin
        kind       = mode_r ? KIND_REG_WR : KIND_REG_RD;
        res_direct = command_r;
      end
      SEL_RDATA:  kind = mode_r ? KIND_NONE : KIND_MEM_RD;
      SEL_WDATA:  kind = mode_r ? KIND_MEM_WR : KIND_REG_RD;
      SEL_STATUS: begin
        kind       = mode_r ? KIND_NONE : KIND_REG_RD;
        res_direct = STATUS_BYTE;
      end
      default:    kind = mode_r ? KIND_NONE : KIND_REG_RD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_latch_r  <= REG_RESET;
      hi_latch_r  <= REG_RESET;
      command_r   <= REG_RESET;
      rptr_r      <= '0;
      wptr_r      <= '0;
    end else if (cmd.reg_write) begin
      unique case (sel)
        SEL_LOW:  lo_latch_r  <= value_r;
        SEL_HIGH: hi_latch_r  <= value_r;
        SEL_CMD: begin
          command_r <= value_r;
          if (value_r != noop_r) begin
            if (value_r[READ_BIT]) begin
              rptr_r <= {hi_latch_r, lo_latch_r};
            end else begin
              wptr_r <= {hi_latch_r, lo_latch_r};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // restoring remainder of the kilobyte index by the size, one bit a cycle
  assign ptr_sel = mode_r ? wptr_r : rptr_r;
  assign trial   = {rem_r, div_r[UPPER_W-1]};
  assign kb_ext  = {1'b0, kb_r};

  always_comb begin
    if (trial >= kb_ext) begin
      rem_nxt = KB_REG_W'(trial - kb_ext);
    end else begin
      rem_nxt = KB_REG_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wrap_start) begin
      div_r  <= ptr_sel[PORT_W-1:KB_SHIFT];
      off_r  <= ptr_sel[KB_SHIFT-1:0];
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.wrap_step) begin
      div_r  <= {div_r[UPPER_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign full_addr = {rem_r, off_r};

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign mem_we    = cmd.clr_step | cmd.mem_write;
  assign mem_addr  = cmd.clr_step ? clr_cnt_r : full_addr[AW-1:0];
  assign mem_wdata = cmd.clr_step ? '0 : value_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_direct) begin
      res_r <= res_direct;
    end else if (cmd.res_mem) begin
      res_r <= mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign status.kind      = kind;
  assign status.clr_last  = (clr_cnt_r == AW'(MEMORY_BYTES - 1));
  assign status.wrap_last = (step_r == STEP_W'(UPPER_W - 1));
  assign status.out_free  = !out_valid_r || out_tready;

  a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_write |-> (rem_r < kb_r))
    else $error("wrapped address beyond size in use");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && !cmd.out_load) |=> $stable(out_data_r))
    else $error("pending result changed");

  a_no_clear_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.clr_step)
    else $error("clearing pass overlaps a bus access");

endmodule

// File: hw/rtl/port_mapped_memory_card_top.sv
// ----------------------------------------------------------------------------
// port_mapped_memory_card_top - I/O-port-mapped byte memory card
// Bus accesses enter on the in_ stream, read bytes leave on the out_ stream,
// port numbers, size and no-op code are set on the cfg_ write port.
//
// Usage:
//   in_tdata carries port and write byte, in_tuser the direction (1 = write).
//   Every read produces one word on out_; writes produce none.
//   One access is worked at a time:
//     address/command register write    taken at decode
//     register, status or unknown read  decode, result register, output register
//     data port write                   decode, bit-serial wrap, memory write
//     data port read                    decode, wrap, memory read, send
//   The wrap unit reduces the kilobyte index modulo the size one bit a cycle.
//   After reset the card memory is cleared one byte a cycle, all MEMORY_BYTES
//   bytes, with in_tready low; cfg_ writes are taken meanwhile.
//   A result waits in the output register while the receiver stalls; the
//   next access is still accepted and holds before delivery until the
//   register is free.
// ----------------------------------------------------------------------------
module port_mapped_memory_card_top #(
  parameter int MEMORY_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] port, [23:16] value
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] read_data
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pmmc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pmmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pmmc_dp #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/tb_port_mapped_memory_card_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_port_mapped_memory_card_top - self-checking bench for the memory card
// Bus accesses are queued by the main sequence and driven on in_ with random
// gaps. Every accepted access runs through a behavioral copy of the card
// (port decode, address latches, pointers, byte memory), and each read word
// on out_ is checked against the oldest predicted byte. Several port maps,
// sizes and no-op codes are programmed between phases while the card is idle.
// ----------------------------------------------------------------------------
module tb_port_mapped_memory_card_top;
  import pmmc_pkg::*;

  localparam int MEMORY_BYTES = 32768;
  localparam int MAX_KB       = MEMORY_BYTES / 1024;
  localparam int SEGMENTS     = 8;
  localparam int RANDOM_ITEMS = 166;

  typedef struct packed {
    logic        mode;
    logic [15:0] port;
    logic [7:0]  value;
  } bus_access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [15:0] port, [23:16] value
  logic        in_tuser = 1'b0; // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] read_data
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  bus_access_t pending_q[$];
  logic [7:0]  read_expect_q[$];
  logic        in_taken = 1'b0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          error_count = 0;
  int          queued_items = 0;

  // behavioral copy of the card
  logic [15:0] cfg_port [6];
  int unsigned card_kb;
  logic [7:0]  noop_code;
  logic [7:0]  lo_latch, hi_latch, command_byte;
  logic [15:0] read_ptr, write_ptr;
  logic [7:0]  card_mem [MEMORY_BYTES];
  logic [15:0] addr_pool [8];

  port_mapped_memory_card_top #(.MEMORY_BYTES(MEMORY_BYTES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic void reset_card_model();
    for (int i = 0; i < 6; i++) cfg_port[i] = 16'(i);
    card_kb      = MAX_KB;
    noop_code    = 8'h00;
    lo_latch     = REG_RESET;
    hi_latch     = REG_RESET;
    command_byte = REG_RESET;
    read_ptr     = '0;
    write_ptr    = '0;
    for (int i = 0; i < MEMORY_BYTES; i++) card_mem[i] = 8'h00;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [15:0] data);
    int unsigned kb;
    case (idx)
      REG_MEMORY_KB: begin
        kb = 32'(data[5:0]);
        // out-of-range sizes keep the previous size
        if (kb >= 1 && kb <= MAX_KB) card_kb = kb;
      end
      REG_NOOP_CODE: noop_code = data[7:0];
      default: cfg_port[idx] = data;
    endcase
  endfunction

  function automatic port_sel_t decode_port(logic [15:0] p);
    if (p == cfg_port[REG_LOW_PORT]) return SEL_LOW;
    if (p == cfg_port[REG_HIGH_PORT]) return SEL_HIGH;
    if (p == cfg_port[REG_COMMAND_PORT]) return SEL_CMD;
    if (p == cfg_port[REG_RDATA_PORT]) return SEL_RDATA;
    if (p == cfg_port[REG_WDATA_PORT]) return SEL_WDATA;
    if (p == cfg_port[REG_STATUS_PORT]) return SEL_STATUS;
    return SEL_NONE;
  endfunction

  function automatic int unsigned wrap_addr(logic [15:0] p);
    return 32'(p) % (card_kb * 1024);
  endfunction

  // Update the card copy with one accepted access; reads queue their byte.
  function automatic void predict_access(logic mode, logic [15:0] port, logic [7:0] value);
    port_sel_t  sel;
    logic [7:0] rd;
    sel = decode_port(port);
    if (!mode) begin
      case (sel)
        SEL_LOW:    rd = lo_latch;
        SEL_HIGH:   rd = hi_latch;
        SEL_CMD:    rd = command_byte;
        SEL_RDATA:  rd = card_mem[wrap_addr(read_ptr)];
        SEL_STATUS: rd = STATUS_BYTE;
        default:    rd = FLOAT_BUS;
      endcase
      read_expect_q.push_back(rd);
    end else begin
      case (sel)
        SEL_LOW:  lo_latch = value;
        SEL_HIGH: hi_latch = value;
        SEL_CMD: begin
          command_byte = value;
          if (value != noop_code) begin
            if (value[READ_BIT]) read_ptr = {hi_latch, lo_latch};
            else write_ptr = {hi_latch, lo_latch};
          end
        end
        SEL_WDATA: card_mem[wrap_addr(write_ptr)] = value;
        default: ;
      endcase
    end
  endfunction

  // driver: present the next access once the current word is taken
  always @(negedge clk) begin
    bus_access_t nxt;
    if (!in_tvalid || in_taken) begin
      if (rst_n && pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.value, nxt.port};
        in_tuser  <= nxt.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    logic [7:0] want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_we) apply_cfg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) predict_access(in_tuser, in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready) begin
        if (read_expect_q.size() == 0) begin
          $display("%0t: unexpected read word %02h, expected none", $time, out_tdata);
          error_count++;
        end else begin
          want = read_expect_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: read_data mismatch: expected %02h, actual %02h",
                     $time, want, out_tdata);
            error_count++;
          end
        end
      end
    end
  end

  task automatic push_access(logic mode, logic [15:0] port, logic [7:0] value);
    bus_access_t a;
    a.mode  = mode;
    a.port  = port;
    a.value = value;
    pending_q.push_back(a);
    queued_items++;
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_card(logic [15:0] lo, logic [15:0] hi, logic [15:0] cmd,
                              logic [15:0] rdp, logic [15:0] wrp, logic [15:0] stp,
                              logic [15:0] kb, logic [15:0] noop);
    write_cfg(REG_LOW_PORT, lo);
    write_cfg(REG_HIGH_PORT, hi);
    write_cfg(REG_COMMAND_PORT, cmd);
    write_cfg(REG_RDATA_PORT, rdp);
    write_cfg(REG_WDATA_PORT, wrp);
    write_cfg(REG_STATUS_PORT, stp);
    write_cfg(REG_MEMORY_KB, kb);
    write_cfg(REG_NOOP_CODE, noop);
  endtask

  // wait at rising edges until the queue, the card and the output are empty
  task automatic drain_card();
    @(posedge clk);
    while (pending_q.size() != 0 || in_tvalid || !in_tready || out_tvalid ||
           read_expect_q.size() != 0)
      @(posedge clk);
    repeat (24) @(negedge clk);
  endtask

  // Mostly address/command/data sequences with random content, some noise.
  task automatic queue_random_traffic(int n);
    int          stop_at;
    logic        to_write;
    logic [15:0] addr;
    logic [7:0]  cmd;
    stop_at = queued_items + n;
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'(card_kb * 1024 - 1);
    addr_pool[2] = 16'hFFFF;
    for (int i = 3; i < 8; i++) addr_pool[i] = 16'($urandom);
    while (queued_items < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        to_write = $urandom_range(0, 1);
        // alias the pool address by whole multiples of the size in use
        addr = 16'(32'(addr_pool[$urandom_range(0, 7)]) + card_kb * 1024 * $urandom_range(0, 3));
        if ($urandom_range(0, 9) != 0) push_access(1'b1, cfg_port[REG_LOW_PORT], addr[7:0]);
        if ($urandom_range(0, 9) != 0) push_access(1'b1, cfg_port[REG_HIGH_PORT], addr[15:8]);
        cmd = {~to_write, 7'($urandom)};
        if ($urandom_range(0, 15) == 0) cmd = noop_code;
        push_access(1'b1, cfg_port[REG_COMMAND_PORT], cmd);
        repeat ($urandom_range(1, 3)) begin
          if (to_write) push_access(1'b1, cfg_port[REG_WDATA_PORT], 8'($urandom));
          else push_access(1'b0, cfg_port[REG_RDATA_PORT], 8'($urandom));
        end
        if ($urandom_range(0, 3) == 0)
          push_access(1'b0, cfg_port[$urandom_range(0, 5)], 8'($urandom));
      end else if ($urandom_range(0, 1) == 0) begin
        push_access(1'($urandom), cfg_port[$urandom_range(0, 5)], 8'($urandom));
      end else begin
        push_access(1'($urandom), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    reset_card_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of every register and an unknown port
    for (int p = 0; p < 7; p++) push_access(1'b0, 16'(p), 8'h00);
    push_access(1'b0, 16'hFFFF, 8'hFF);
    push_access(1'b1, 16'd0, 8'hFF);
    push_access(1'b1, 16'd1, 8'h7F);
    push_access(1'b1, 16'd2, 8'h00);     // no-op command sets no pointer
    push_access(1'b1, 16'd4, 8'h11);
    push_access(1'b1, 16'd2, 8'h01);     // write pointer <- 0x7FFF
    push_access(1'b1, 16'd4, 8'hA5);
    push_access(1'b1, 16'd2, 8'h81);     // read pointer <- 0x7FFF
    push_access(1'b0, 16'd3, 8'h00);
    push_access(1'b1, 16'd3, 8'h5A);     // write to the read data port: no effect
    push_access(1'b1, 16'd5, 8'hFF);     // status write: no effect
    push_access(1'b1, 16'hFFFF, 8'h00);  // unknown port write: no effect
    push_access(1'b0, 16'd3, 8'hFF);
    push_access(1'b0, 16'd2, 8'h00);
    push_access(1'b1, 16'd0, 8'h00);
    push_access(1'b1, 16'd1, 8'h00);
    push_access(1'b1, 16'd2, 8'hFF);
    push_access(1'b0, 16'd3, 8'h00);
    push_access(1'b0, 16'd0, 8'h00);
    push_access(1'b0, 16'd1, 8'h00);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_card();
      case (seg)
        0: ;
        1: program_card(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'd1, 16'h00FF);
        2: program_card(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00,
                        16'd32, 16'h0080);
        3: begin
          // coinciding ports: the earlier one in priority wins
          program_card(16'h0010, 16'h0010, 16'h0020, 16'h0030, 16'h0030, 16'h0020,
                       16'd8, 16'($urandom));
          write_cfg(REG_MEMORY_KB, 16'd0);
          write_cfg(REG_MEMORY_KB, 16'd33);
        end
        4: begin
          program_card(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'd63, 16'($urandom));
          write_cfg(REG_MEMORY_KB, 16'h0045);
        end
        5: program_card(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom_range(1, MAX_KB)),
                        16'($urandom));
        6: program_card(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'hFFD0, 16'hFF00 | 16'($urandom));
        default: program_card(16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5,
                              16'd31, 16'h0000);
      endcase
      @(negedge clk);
      case (seg % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
        default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
      endcase
      queue_random_traffic(RANDOM_ITEMS);
    end

    drain_card();
    if (error_count == 0 && read_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// File: port_mapped_memory_card_top.f
hw/rtl/pmmc_pkg.sv
hw/rtl/pmmc_ctrl.sv
hw/rtl/pmmc_dp.sv
hw/rtl/port_mapped_memory_card_top.sv
tb/tb_port_mapped_memory_card_top.sv
